[rtl/schedule_rule_matcher_top_defines.svh]
`ifndef SCHEDULE_RULE_MATCHER_TOP_DEFINES_SVH
`define SCHEDULE_RULE_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SRM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("schedule rule matcher check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define SRM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("schedule rule matcher check failed");

`endif

[rtl/srm_pkg.sv]
package srm_pkg;

   localparam int RULE_SLOTS  = 16;
   localparam int IDX_W       = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W       = 5;
   localparam int ACT_W       = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic signed [5:0]  NO_HOUR   = -6'sd1;
   localparam logic signed [14:0] NO_TEMP   = -15'sd9990;
   localparam logic [ACT_W-1:0]   OFF_STATE = 48'd6144;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic REG_RULE_COUNT = 1'b0;
   localparam logic REG_DEBUG_MODE = 1'b1;

   typedef struct packed {
      logic               enabled;
      logic [15:0]        id;
      logic signed [5:0]  start_hour;
      logic signed [5:0]  end_hour;
      logic signed [14:0] min_temp;
      logic signed [14:0] max_temp;
   } rule_cond_type;

   typedef struct packed {
      rule_cond_type    cond;
      logic [ACT_W-1:0] action;
   } rule_entry_type;

   localparam int ENTRY_W = $bits(rule_entry_type);

   typedef struct packed {
      logic               is_write;
      logic [IDX_W-1:0]   index;
      rule_entry_type     entry;
      logic [4:0]         hour;
      logic signed [11:0] temp;
   } op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/srm_ram.sv]
module srm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/srm_front.sv]
module srm_front
   import srm_pkg::*;
(
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [3:0]          req_rule_index,
   input  logic                req_rule_enabled,
   input  logic [15:0]         req_rule_id,
   input  logic signed [5:0]   req_start_hour,
   input  logic signed [5:0]   req_end_hour,
   input  logic signed [14:0]  req_min_temp,
   input  logic signed [14:0]  req_max_temp,
   input  logic [47:0]         req_action_word,
   input  logic [4:0]          req_current_hour,
   input  logic signed [11:0]  req_current_temp,
   input  logic                req_temp_valid,
   input  queue_status_type    q_status,
   output logic                q_push,
   output op_type              q_op
);

   logic index_ok;
   logic keep;

   assign req_stall = q_status.full;
   assign index_ok  = (32'(req_rule_index) < RULE_SLOTS);

   always_comb begin
      keep = 1'b0;
      case (req_opcode)
         OP_WRITE: keep = index_ok;
         OP_EVAL:  keep = req_temp_valid;
         default:  keep = 1'b0;
      endcase
   end

   assign q_push = req_valid && !q_status.full && keep;

   always_comb begin
      q_op                        = '0;
      q_op.is_write               = (req_opcode == OP_WRITE);
      q_op.index                  = IDX_W'(req_rule_index);
      q_op.entry.cond.enabled     = req_rule_enabled;
      q_op.entry.cond.id          = req_rule_id;
      q_op.entry.cond.start_hour  = req_start_hour;
      q_op.entry.cond.end_hour    = req_end_hour;
      q_op.entry.cond.min_temp    = req_min_temp;
      q_op.entry.cond.max_temp    = req_max_temp;
      q_op.entry.action           = {req_action_word[47:8], 7'd0, (req_action_word[7:0] != 8'd0)};
      q_op.hour                   = req_current_hour;
      q_op.temp                   = req_current_temp;
   end

endmodule

[rtl/srm_queue.sv]
module srm_queue
   import srm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_op,
   input  logic             pop,
   output op_type           head_op,
   output queue_status_type status
);

   op_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_op      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[rtl/srm_back.sv]
module srm_back
   import srm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   input  op_type              q_head,
   output logic                q_pop,
   input  logic [CNT_W-1:0]    rule_count,
   input  logic                debug_mode,
   output logic                ram_we,
   output logic [IDX_W-1:0]    ram_waddr,
   output logic [ENTRY_W-1:0]  ram_wdata,
   output logic [IDX_W-1:0]    ram_raddr,
   input  logic [ENTRY_W-1:0]  ram_rdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_matched,
   output logic [15:0]         rsp_active_rule_id,
   output logic                rsp_send_command,
   output logic                rsp_forced,
   output logic [47:0]         rsp_command_word
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [4:0]         hour_ff;
   logic [4:0]         hour_in;
   logic signed [11:0] temp_ff;
   logic signed [11:0] temp_in;
   logic [ACT_W-1:0]   tracked_ff;
   logic [ACT_W-1:0]   tracked_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_matched_ff;
   logic               rsp_matched_in;
   logic [15:0]        rsp_id_ff;
   logic [15:0]        rsp_id_in;
   logic               rsp_send_ff;
   logic               rsp_send_in;
   logic               rsp_forced_ff;
   logic               rsp_forced_in;
   logic [ACT_W-1:0]   rsp_word_ff;
   logic [ACT_W-1:0]   rsp_word_in;

   rule_entry_type     cur;
   logic signed [6:0]  hour_s;
   logic signed [6:0]  start_s;
   logic signed [6:0]  end_s;
   logic signed [14:0] temp_s;
   logic               time_ok;
   logic               hit;
   logic [CNT_W-1:0]   limit;
   logic               last;
   logic               out_free;
   logic               changed;
   logic               was_on;

   assign cur     = rule_entry_type'(ram_rdata);
   assign hour_s  = $signed({2'b00, hour_ff});
   assign start_s = $signed({cur.cond.start_hour[5], cur.cond.start_hour});
   assign end_s   = $signed({cur.cond.end_hour[5], cur.cond.end_hour});
   assign temp_s  = $signed({{3{temp_ff[11]}}, temp_ff});

   always_comb begin
      time_ok = 1'b1;
      if (cur.cond.start_hour != NO_HOUR && cur.cond.end_hour != NO_HOUR) begin
         if (end_s > start_s) begin
            time_ok = (hour_s >= start_s) && (hour_s < end_s);
         end else begin
            time_ok = (hour_s >= start_s) || (hour_s < end_s);
         end
      end
   end

   assign hit = cur.cond.enabled && time_ok
             && !(cur.cond.min_temp != NO_TEMP && temp_s < cur.cond.min_temp)
             && !(cur.cond.max_temp != NO_TEMP && temp_s > cur.cond.max_temp);

   assign limit    = (32'(rule_count) >= RULE_SLOTS) ? CNT_W'(RULE_SLOTS) : rule_count;
   assign last     = (CNT_W'(idx_ff) + CNT_W'(1) == limit);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign changed  = (cur.action != tracked_ff);
   assign was_on   = (tracked_ff[7:0] != 8'd0);

   assign ram_waddr = q_head.index;
   assign ram_wdata = ENTRY_W'(q_head.entry);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      hour_in        = hour_ff;
      temp_in        = temp_ff;
      tracked_in     = tracked_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_send_in    = rsp_send_ff;
      rsp_forced_in  = rsp_forced_ff;
      rsp_word_in    = rsp_word_ff;
      q_pop          = 1'b0;
      ram_we         = 1'b0;
      ram_raddr      = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_raddr = '0;
            if (!q_status.empty) begin
               if (q_head.is_write) begin
                  q_pop  = 1'b1;
                  ram_we = 1'b1;
               end else if (limit != '0) begin
                  q_pop    = 1'b1;
                  hour_in  = q_head.hour;
                  temp_in  = q_head.temp;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else if (out_free) begin
                  q_pop          = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b0;
                  rsp_id_in      = '0;
                  rsp_send_in    = was_on || debug_mode;
                  rsp_forced_in  = debug_mode && !was_on;
                  tracked_in     = (was_on || debug_mode) ? OFF_STATE : tracked_ff;
                  rsp_word_in    = (was_on || debug_mode) ? OFF_STATE : tracked_ff;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b1;
                  rsp_id_in      = cur.cond.id;
                  rsp_send_in    = changed || debug_mode;
                  rsp_forced_in  = debug_mode && !changed;
                  tracked_in     = (changed || debug_mode) ? cur.action : tracked_ff;
                  rsp_word_in    = (changed || debug_mode) ? cur.action : tracked_ff;
                  state_in       = ST_IDLE;
               end
            end else if (last) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b0;
                  rsp_id_in      = '0;
                  rsp_send_in    = was_on || debug_mode;
                  rsp_forced_in  = debug_mode && !was_on;
                  tracked_in     = (was_on || debug_mode) ? OFF_STATE : tracked_ff;
                  rsp_word_in    = (was_on || debug_mode) ? OFF_STATE : tracked_ff;
                  state_in       = ST_IDLE;
               end
            end else begin
               idx_in    = idx_ff + 1'b1;
               ram_raddr = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tracked_ff   <= OFF_STATE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tracked_ff   <= tracked_in;
      end
      idx_ff         <= idx_in;
      hour_ff        <= hour_in;
      temp_ff        <= temp_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_send_ff    <= rsp_send_in;
      rsp_forced_ff  <= rsp_forced_in;
      rsp_word_ff    <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_active_rule_id = rsp_id_ff;
   assign rsp_send_command   = rsp_send_ff;
   assign rsp_forced         = rsp_forced_ff;
   assign rsp_command_word   = rsp_word_ff;

endmodule

[rtl/schedule_rule_matcher_top.sv]
// Order: an accepted rule write waits in the queue and is written to the rule table when the idle back
// end pops it. An evaluate is popped by the idle back end, which reads rules from slot 0 upward and
// registers the result on the first winning rule or after the last of the n rules; a stall holds it.
// Throughput: one rule write per cycle while idle; evaluations run one at a time, one entry a cycle.
// Reset: synchronous, clears the queue and the output, sets the tracked state to power off at
// 24 degrees and both registers to zero; the rule table holds no value until written.
module schedule_rule_matcher_top
   import srm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [3:0]         req_rule_index,
   input  logic               req_rule_enabled,
   input  logic [15:0]        req_rule_id,
   input  logic signed [5:0]  req_start_hour,
   input  logic signed [5:0]  req_end_hour,
   input  logic signed [14:0] req_min_temp,
   input  logic signed [14:0] req_max_temp,
   input  logic [47:0]        req_action_word,
   input  logic [4:0]         req_current_hour,
   input  logic signed [11:0] req_current_temp,
   input  logic               req_temp_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_matched,
   output logic [15:0]        rsp_active_rule_id,
   output logic               rsp_send_command,
   output logic               rsp_forced,
   output logic [47:0]        rsp_command_word,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [CNT_W-1:0]   rule_count_ff;
   logic [CNT_W-1:0]   rule_count_in;
   logic               debug_mode_ff;
   logic               debug_mode_in;
   logic               csr_write;
   queue_status_type   q_status;
   logic               q_push;
   logic               q_pop;
   op_type             q_op;
   op_type             q_head;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      rule_count_in = rule_count_ff;
      debug_mode_in = debug_mode_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_RULE_COUNT: rule_count_in = pwdata[CNT_W-1:0];
            REG_DEBUG_MODE: debug_mode_in = pwdata[0];
            default: begin
               rule_count_in = rule_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RULE_COUNT: prdata = {{(32 - CNT_W){1'b0}}, rule_count_ff};
         REG_DEBUG_MODE: prdata = {31'd0, debug_mode_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         debug_mode_ff <= 1'b0;
      end else begin
         rule_count_ff <= rule_count_in;
         debug_mode_ff <= debug_mode_in;
      end
   end

   srm_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_rule_index   (req_rule_index),
      .req_rule_enabled (req_rule_enabled),
      .req_rule_id      (req_rule_id),
      .req_start_hour   (req_start_hour),
      .req_end_hour     (req_end_hour),
      .req_min_temp     (req_min_temp),
      .req_max_temp     (req_max_temp),
      .req_action_word  (req_action_word),
      .req_current_hour (req_current_hour),
      .req_current_temp (req_current_temp),
      .req_temp_valid   (req_temp_valid),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_op             (q_op)
   );

   srm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_op),
      .pop     (q_pop),
      .head_op (q_head),
      .status  (q_status)
   );

   srm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RULE_SLOTS)
   ) u_rule_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   srm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rule_count         (rule_count_ff),
      .debug_mode         (debug_mode_ff),
      .ram_we             (ram_we),
      .ram_waddr          (ram_waddr),
      .ram_wdata          (ram_wdata),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_matched        (rsp_matched),
      .rsp_active_rule_id (rsp_active_rule_id),
      .rsp_send_command   (rsp_send_command),
      .rsp_forced         (rsp_forced),
      .rsp_command_word   (rsp_command_word)
   );

endmodule

[rtl/srm_checker.sv]
`include "schedule_rule_matcher_top_defines.svh"

module srm_checker
   import srm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_matched,
   input logic [15:0] rsp_active_rule_id,
   input logic        rsp_send_command,
   input logic        rsp_forced,
   input logic [47:0] rsp_command_word
);

   `SRM_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SRM_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                   $stable({rsp_command_word, rsp_active_rule_id}))
   `SRM_ASSERT_IMP(a_forced_needs_send, clock, reset, rsp_valid && !rsp_send_command, !rsp_forced)
   `SRM_ASSERT_IMP(a_no_match_id, clock, reset, rsp_valid && !rsp_matched, rsp_active_rule_id == 16'd0)
   `SRM_ASSERT_IMP(a_no_match_off, clock, reset, rsp_valid && !rsp_matched && rsp_send_command,
                   rsp_command_word == OFF_STATE)

endmodule

bind schedule_rule_matcher_top srm_checker u_srm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_matched        (rsp_matched),
   .rsp_active_rule_id (rsp_active_rule_id),
   .rsp_send_command   (rsp_send_command),
   .rsp_forced         (rsp_forced),
   .rsp_command_word   (rsp_command_word)
);
